// ----- src/bin_index_by_edges_core_defines.svh -----
// -----------------------------------------------------------------------------
// Assertion macros for the bin index core
// Shared macros that wrap a clocked property with reset disable and reporting.
// -----------------------------------------------------------------------------
`ifndef BIN_INDEX_BY_EDGES_CORE_DEFINES_SVH
`define BIN_INDEX_BY_EDGES_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BIE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BIE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bie_pkg.sv -----
// -----------------------------------------------------------------------------
// Bin index core package
// Widths, register indexes, opcodes, shared types and the scan state encoding.
// -----------------------------------------------------------------------------
`default_nettype none

package bie_pkg;

  localparam int MaxEdgesDefault   = 16;
  localparam int ValueWidthDefault = 32;

  localparam int SlotWidth     = 4;
  localparam int BinWidth      = 5;
  localparam int CfgDataWidth  = 5;
  localparam int CfgIndexWidth = 2;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] CfgLeftClosed = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgSortedMode = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CfgEdgeCount  = 2'd2;

  // Register reset values.
  localparam logic                LeftClosedReset = 1'b1;
  localparam logic                SortedModeReset = 1'b0;
  localparam logic [BinWidth-1:0] EdgeCountReset  = 5'd16;

  // Item opcodes.
  localparam logic OpLoad     = 1'b0;
  localparam logic OpClassify = 1'b1;

  typedef struct packed {
    logic                left_closed;
    logic                sorted_mode;
    logic [BinWidth-1:0] edge_count;
  } bie_cfg_t;

  typedef enum logic [1:0] {
    StIdle,
    StFetch,
    StScan,
    StHold
  } bie_state_e;

endpackage

`default_nettype wire

// ----- src/bin_index_by_edges_core.sv -----
// -----------------------------------------------------------------------------
// Bin index by edges core
// Histogram bin index against a table of ascending bin edges in memory.
// -----------------------------------------------------------------------------
// A load beat (opcode 0) writes sample_value into edge slot edge_slot. A
// classify beat (opcode 1) returns in bin_index the number of leading edges
// that the value meets (value >= edge when left_closed is set, value > edge
// otherwise), from 0 up to the edge count in use. The edges sit in a single
// synchronous RAM with one read port, so the scan compares one edge per
// cycle: a classify beat holds the core through its fetch and a scan of at most
// the edge count of edges (16 with the defaults) before the next beat is taken.
// In sorted mode the scan resumes from the index of the previous value of the
// run, so ascending runs cost only the edges they pass over; last_of_run
// returns that position to zero. The result sits in an output register, so a
// new beat is taken while it waits. A later result that finds that register
// still full is held in the core, and the input stays stalled until the
// register is read. Edges must be loaded before they are used; configuration
// must be written only while the core is idle, which the core does not enforce.
// -----------------------------------------------------------------------------
`default_nettype none

module bin_index_by_edges_core import bie_pkg::*; #(
  parameter int MAX_EDGES   = MaxEdgesDefault,
  parameter int VALUE_WIDTH = ValueWidthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Configuration write port.
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [CfgDataWidth-1:0]  cfg_data_i,
  // Input channel.
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     opcode_i,
  input  wire logic [SlotWidth-1:0]     edge_slot_i,
  input  wire logic [VALUE_WIDTH-1:0]   sample_value_i,
  input  wire logic                     last_of_run_i,
  // Result channel.
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic      [BinWidth-1:0]      bin_index_o
);

  localparam int AddrWidth = $clog2(MAX_EDGES);

  bie_cfg_t cfg_q;

  logic                   ram_we;
  logic [AddrWidth-1:0]   ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [AddrWidth-1:0]   ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  // Configuration registers. Writes to an index past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_closed <= LeftClosedReset;
      cfg_q.sorted_mode <= SortedModeReset;
      cfg_q.edge_count  <= EdgeCountReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgLeftClosed) begin
        cfg_q.left_closed <= cfg_data_i[0];
      end else if (cfg_index_i == CfgSortedMode) begin
        cfg_q.sorted_mode <= cfg_data_i[0];
      end else if (cfg_index_i == CfgEdgeCount) begin
        cfg_q.edge_count <= cfg_data_i[BinWidth-1:0];
      end
    end
  end

  // The edge table: one entry per edge, written by load beats and read
  // one entry a cycle by the scan.
  bie_ram #(
    .Width (VALUE_WIDTH),
    .Depth (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The sequencer takes beats, issues the reads ahead of each compare and
  // keeps the sorted-mode scan position.
  bie_scan #(
    .MAX_EDGES   (MAX_EDGES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .edge_slot_i    (edge_slot_i),
    .sample_value_i (sample_value_i),
    .last_of_run_i  (last_of_run_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bin_index_o    (bin_index_o),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

endmodule

`default_nettype wire

// ----- src/bie_ram.sv -----
// -----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with the read data registered.
// -----------------------------------------------------------------------------
`default_nettype none

module bie_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/bie_scan.sv -----
// -----------------------------------------------------------------------------
// Bin index scan sequencer
// Accepts beats, writes edges, walks the edge memory and holds the result.
// -----------------------------------------------------------------------------
`default_nettype none

`include "bin_index_by_edges_core_defines.svh"

module bie_scan import bie_pkg::*; #(
  parameter int MAX_EDGES   = MaxEdgesDefault,
  parameter int VALUE_WIDTH = ValueWidthDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bie_cfg_t                     cfg_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         opcode_i,
  input  wire logic [SlotWidth-1:0]         edge_slot_i,
  input  wire logic [VALUE_WIDTH-1:0]       sample_value_i,
  input  wire logic                         last_of_run_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [BinWidth-1:0]          bin_index_o,
  output logic                              ram_we_o,
  output logic      [$clog2(MAX_EDGES)-1:0] ram_waddr_o,
  output logic      [VALUE_WIDTH-1:0]       ram_wdata_o,
  output logic                              ram_re_o,
  output logic      [$clog2(MAX_EDGES)-1:0] ram_raddr_o,
  input  wire logic [VALUE_WIDTH-1:0]       ram_rdata_i
);

  localparam int AddrWidth = $clog2(MAX_EDGES);

  bie_state_e state_q, state_d;

  logic [BinWidth-1:0]    k_q, k_d;
  logic [BinWidth-1:0]    count_q, count_d;
  logic [BinWidth-1:0]    scan_pos_q, scan_pos_d;
  logic                   last_q, last_d;
  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic                   out_valid_q, out_valid_d;
  logic [BinWidth-1:0]    bin_q, bin_d;

  logic                   in_accept;
  logic [BinWidth-1:0]    count_w;
  logic [BinWidth-1:0]    start_w;
  logic [BinWidth-1:0]    k_next;
  logic                   meets;
  logic                   out_free;
  logic                   finish;
  logic [BinWidth-1:0]    k_fin;
  logic [SlotWidth-1:0]   slot_rem;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign out_free = !out_valid_q || !out_stall_i;
  assign k_next = k_q + BinWidth'(1);

  // Edge count clamped to the table size, and the sorted-mode start point.
  always_comb begin
    if (32'(cfg_i.edge_count) > MAX_EDGES) begin
      count_w = BinWidth'(MAX_EDGES);
    end else begin
      count_w = cfg_i.edge_count;
    end
    if (!cfg_i.sorted_mode) begin
      start_w = '0;
    end else if (scan_pos_q > count_w) begin
      start_w = count_w;
    end else begin
      start_w = scan_pos_q;
    end
  end

  // Slot folded onto the table depth; a few narrow subtract steps at most.
  always_comb begin
    slot_rem = edge_slot_i;
    for (int i = 0; i < 8; i++) begin
      if (32'(slot_rem) >= MAX_EDGES) begin
        slot_rem = slot_rem - SlotWidth'(MAX_EDGES);
      end
    end
  end

  assign ram_we_o    = in_accept && (opcode_i == OpLoad);
  assign ram_waddr_o = AddrWidth'(slot_rem);
  assign ram_wdata_o = sample_value_i;
  assign ram_re_o    = (state_q == StFetch) || (state_q == StScan);
  assign ram_raddr_o = (state_q == StScan) ? AddrWidth'(k_next) : AddrWidth'(k_q);

  always_comb begin
    if (cfg_i.left_closed) begin
      meets = $signed(value_q) >= $signed(ram_rdata_i);
    end else begin
      meets = $signed(value_q) > $signed(ram_rdata_i);
    end
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    count_d     = count_q;
    last_d      = last_q;
    value_d     = value_q;
    scan_pos_d  = scan_pos_q;
    bin_d       = bin_q;
    finish      = 1'b0;
    k_fin       = k_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      StIdle: begin
        if (in_accept && (opcode_i == OpClassify)) begin
          k_d     = start_w;
          count_d = count_w;
          last_d  = last_of_run_i;
          value_d = sample_value_i;
          state_d = StFetch;
        end
      end
      StFetch: begin
        if (k_q < count_q) begin
          state_d = StScan;
        end else begin
          finish = 1'b1;
        end
      end
      StScan: begin
        if (meets && (k_next < count_q)) begin
          k_d = k_next;
        end else begin
          finish = 1'b1;
          k_fin  = meets ? k_next : k_q;
        end
      end
      StHold: begin
        if (out_free) begin
          bin_d       = k_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (finish) begin
      k_d = k_fin;
      if (last_q) begin
        scan_pos_d = '0;
      end else if (cfg_i.sorted_mode) begin
        scan_pos_d = k_fin;
      end
      if (out_free) begin
        bin_d       = k_fin;
        out_valid_d = 1'b1;
        state_d     = StIdle;
      end else begin
        state_d = StHold;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      scan_pos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_pos_q  <= scan_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    count_q <= count_d;
    last_q  <= last_d;
    value_q <= value_d;
    bin_q   <= bin_d;
  end

  assign out_valid_o = out_valid_q;
  assign bin_index_o = bin_q;

  `BIE_ASSERT_NXT(a_load_stays_idle, in_accept && (opcode_i == OpLoad), state_q == StIdle, "load beat left the idle state")
  `BIE_ASSERT_NXT(a_classify_fetches, in_accept && (opcode_i == OpClassify), state_q == StFetch, "classify beat did not start a fetch")
  `BIE_ASSERT_IMP(a_scan_in_range, state_q == StScan, k_q < count_q, "scan index reached the edge count")
  `BIE_ASSERT_IMP(a_result_from_scan, $rose(out_valid_q), ($past(state_q) == StFetch) || ($past(state_q) == StScan) || ($past(state_q) == StHold), "result appeared without a scan")

endmodule

`default_nettype wire
